FILE: rtl/adsum_pkg.sv
// Package for the assignment distance sum block: sizes, state and command types.
`timescale 1ns / 1ps
package adsum_pkg;

  localparam int AP_COUNT    = 64;
  localparam int AP_IDX_W    = (AP_COUNT > 1) ? $clog2(AP_COUNT) : 1;
  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * COORD_W + 1;        // sum of two squares
  localparam int FRAC_BITS   = 8;
  localparam int RAD_W       = SQ_W + 2 * FRAC_BITS + 1; // padded to an even width
  localparam int ROOT_STEPS  = RAD_W / 2;
  localparam int ROOT_W      = ROOT_STEPS;
  localparam int REM_W       = ROOT_W + 2;
  localparam int STEP_CNT_W  = $clog2(ROOT_STEPS);
  localparam int SUM_W       = 35;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_RINIT,
    ST_ROOT,
    ST_ACC
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_ap;      // load word accepted
    logic take_client;  // client word accepted: capture and start table read
    logic calc_diff;
    logic sq_x;
    logic sq_y;
    logic root_init;
    logic root_step;
    logic accum;        // add distance to the sum
    logic emit;         // latch the result and clear the sum
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;
  } status_t;

endpackage

FILE: rtl/assignment_distance_sum.sv
// A client word keeps the input busy through its differences, squares, the 25-step
// digit-by-digit square root and the sum; a last client's sum is valid the cycle after.
// Loads are taken one per cycle in idle; a new client only once the last one is done.
// The input is taken again while a result still waits in the output register.
// Reset clears the control state, the running sum and its overflow flag; the access point
// table stays undefined until written.
`timescale 1ns / 1ps
module assignment_distance_sum import adsum_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [5:0]        ap_index_i,
  input  logic signed [15:0] coord_x_i,
  input  logic signed [15:0] coord_y_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [34:0]       distance_total_o,
  output logic              overflowed_o
);

  cmd_t    cmd;
  status_t status;

  adsum_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adsum_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .ap_index_i      (ap_index_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .last_i          (last_i),
    .distance_total_o(distance_total_o),
    .overflowed_o    (overflowed_o)
  );

endmodule

FILE: rtl/adsum_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module adsum_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write or read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/adsum_ctrl.sv
// Controller state machine for the assignment distance sum block.
`timescale 1ns / 1ps
module adsum_ctrl import adsum_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    kind_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e                state_q, state_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;

  // hold state, step count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // sequence a client word through difference, squares, root and sum; take load words in idle
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    // drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (kind_i) begin
            cmd_o.take_client = 1'b1;
            state_d           = ST_DIFF;
          end else begin
            cmd_o.load_ap = 1'b1;
          end
        end
      end
      ST_DIFF: begin
        cmd_o.calc_diff = 1'b1;
        state_d         = ST_SQX;
      end
      ST_SQX: begin
        cmd_o.sq_x = 1'b1;
        state_d    = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.sq_y = 1'b1;
        state_d    = ST_RINIT;
      end
      ST_RINIT: begin
        cmd_o.root_init = 1'b1;
        cnt_d           = '0;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == STEP_CNT_W'(ROOT_STEPS - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        // a last client waits while a previous result still sits in the output register
        if (!status_i.last) begin
          cmd_o.accum = 1'b1;
          state_d     = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.accum = 1'b1;
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/adsum_dp.sv
// Datapath: access point table, differences, squares, square root and running sum.
`timescale 1ns / 1ps
module adsum_dp import adsum_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [5:0]         ap_index_i,
  input  logic [COORD_W-1:0] coord_x_i,
  input  logic [COORD_W-1:0] coord_y_i,
  input  logic               last_i,
  output logic [SUM_W-1:0]   distance_total_o,
  output logic               overflowed_o
);

  logic                    in_range;
  logic [2*COORD_W-1:0]    ram_rdata;
  logic [COORD_W-1:0]      cx_q, cy_q;
  logic                    hit_q, last_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic signed [DIFF_W-1:0] ax, ay;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]         sqx_q, sqy_q;
  logic [RAD_W-1:0]        rad_q;
  logic [REM_W-1:0]        rem_q;
  logic [ROOT_W-1:0]       root_q;
  logic [REM_W+1:0]        rem_shift, trial;
  logic [SUM_W-1:0]        sum_q;
  logic                    sat_q;
  logic [SUM_W:0]          sum_add;
  logic [SUM_W-1:0]        sum_next;
  logic                    sat_next;
  logic [SUM_W-1:0]        total_q;
  logic                    ovf_q;

  assign in_range = (32'(ap_index_i) < AP_COUNT);

  // access point coordinates, x in the upper half
  adsum_ram #(
    .Width(2 * COORD_W),
    .Depth(AP_COUNT)
  ) u_ap_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_ap && in_range),
    .addr_i (ap_index_i[AP_IDX_W-1:0]),
    .wdata_i({coord_x_i, coord_y_i}),
    .rdata_o(ram_rdata)
  );

  // read an out-of-range entry as the origin
  assign ax = hit_q ? DIFF_W'($signed(ram_rdata[2*COORD_W-1:COORD_W])) : '0;
  assign ay = hit_q ? DIFF_W'($signed(ram_rdata[COORD_W-1:0])) : '0;

  // share one multiplier between the two squares
  assign prod = cmd_i.sq_x ? (dx_q * dx_q) : (dy_q * dy_q);

  // one root digit: bring down two bits and try the next one
  assign rem_shift = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial     = {2'b00, root_q, 2'b01};

  // add with saturation
  assign sum_add  = {1'b0, sum_q} + (SUM_W + 1)'(root_q);
  assign sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign sat_next = sat_q | sum_add[SUM_W];

  // capture the client word and work out differences, squares and root
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_client) begin
      cx_q   <= coord_x_i;
      cy_q   <= coord_y_i;
      hit_q  <= in_range;
      last_q <= last_i;
    end
    if (cmd_i.calc_diff) begin
      dx_q <= DIFF_W'($signed(cx_q)) - ax;
      dy_q <= DIFF_W'($signed(cy_q)) - ay;
    end
    if (cmd_i.sq_x) begin
      sqx_q <= prod[SQ_W-1:0];
    end
    if (cmd_i.sq_y) begin
      sqy_q <= prod[SQ_W-1:0];
    end
    if (cmd_i.root_init) begin
      rad_q  <= {1'b0, (sqx_q + sqy_q), {(2 * FRAC_BITS){1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_shift >= trial) begin
        rem_q  <= REM_W'(rem_shift - trial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_shift[REM_W-1:0];
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      total_q <= sum_next;
      ovf_q   <= sat_next;
    end
  end

  // hold the running sum and its flag, clear them after an emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.emit) begin
      sum_q <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.accum) begin
      sum_q <= sum_next;
      sat_q <= sat_next;
    end
  end

  assign status_o.last    = last_q;
  assign distance_total_o = total_q;
  assign overflowed_o     = ovf_q;

endmodule
